>>> hdl/coa_pkg.sv
// ----------------------------------------------------------------------------
// Chunked object pool package
// Widths, codes and state encoding shared by the pool allocator files.
// ----------------------------------------------------------------------------
`default_nettype none

package coa_pkg;

   localparam int unsigned CHUNK_LIMIT = 8;
   localparam int unsigned OBJS_MAX    = 64;

   localparam int unsigned CHUNK_W  = $clog2(CHUNK_LIMIT);
   localparam int unsigned OBJ_W    = $clog2(OBJS_MAX);
   localparam int unsigned HEAD_W   = OBJ_W + 1;
   localparam int unsigned SLOT_W   = CHUNK_W + OBJ_W;
   localparam int unsigned ACTIVE_W = CHUNK_W + 1;
   localparam int unsigned SLOTS    = CHUNK_LIMIT * OBJS_MAX;
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned STATUS_W = 2;

   localparam logic [HEAD_W-1:0]   LIST_END    = HEAD_W'(OBJS_MAX);
   localparam logic [ACTIVE_W-1:0] ACTIVE_MAX  = ACTIVE_W'(CHUNK_LIMIT - 1);
   localparam logic [HEAD_W-1:0]   OPC_RESET   = HEAD_W'(OBJS_MAX);

   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_OUTSIDE   = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_POP  = 6'b000100,
      ST_LINK = 6'b001000,
      ST_FREE = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

endpackage

`default_nettype wire

>>> hdl/coa_req_if.sv
// ----------------------------------------------------------------------------
// Pool request channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface coa_req_if;
   logic                          valid;
   logic                          ready;
   logic [coa_pkg::CMD_W-1:0]     command;
   logic [coa_pkg::SLOT_W-1:0]    free_slot;

   modport source (output valid, command, free_slot, input ready);
   modport sink   (input valid, command, free_slot, output ready);
endinterface

`default_nettype wire

>>> hdl/coa_rsp_if.sv
// ----------------------------------------------------------------------------
// Pool response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface coa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [coa_pkg::SLOT_W-1:0]    slot;
   logic [coa_pkg::STATUS_W-1:0]  status;
   logic                          grew;

   modport source (output valid, slot, status, grew, input ready);
   modport sink   (input valid, slot, status, grew, output ready);
endinterface

`default_nettype wire

>>> hdl/chunked_object_pool_allocator.sv
// Steps: clear and unknown words go straight to the done state; free passes the free
// state; alloc scans chunk heads from chunk 0, then pops, opens a chunk or fails.
// Flow: one word in work at a time; the next word is accepted only once the result
// of the last one is loaded into the response register, so rsp_if can hold it off.
// Reset: synchronous, clears state, open chunk count and the response valid;
// object count returns to 64. Link memory and chunk heads need no clearing.
// ----------------------------------------------------------------------------
// Chunked object pool allocator
// Per-chunk LIFO free lists over a slot link memory, driven by a small
// sequencer that scans chunk heads and fills new chunk lists.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_object_pool_allocator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   coa_req_if.sink                             req_if,
   coa_rsp_if.source                           rsp_if,
   input  wire logic                           csr_wr_en,
   input  wire logic [coa_pkg::HEAD_W-1:0]     csr_wr_data
);

   localparam int unsigned CHUNK_W  = coa_pkg::CHUNK_W;
   localparam int unsigned OBJ_W    = coa_pkg::OBJ_W;
   localparam int unsigned HEAD_W   = coa_pkg::HEAD_W;
   localparam int unsigned SLOT_W   = coa_pkg::SLOT_W;
   localparam int unsigned ACTIVE_W = coa_pkg::ACTIVE_W;
   localparam int unsigned STATUS_W = coa_pkg::STATUS_W;

   coa_pkg::state_type state_ff, state_in;

   logic [HEAD_W-1:0]   opc_ff;
   logic [CHUNK_W-1:0]  cnt_ff, cnt_in;
   logic [OBJ_W-1:0]    obj_ff, obj_in;
   logic [OBJ_W-1:0]    lnk_ff, lnk_in;
   logic [HEAD_W-1:0]   n_ff, n_in;
   logic [ACTIVE_W-1:0] active_ff, active_in;

   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                res_grew_ff, res_grew_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_grew_ff;
   logic                rsp_load;

   logic [HEAD_W-1:0]   chunk_head_ff [coa_pkg::CHUNK_LIMIT];
   logic                head_we;
   logic [HEAD_W-1:0]   head_wdata;

   logic [HEAD_W-1:0]   slot_link_mem [coa_pkg::SLOTS];
   logic                mem_we;
   logic [SLOT_W-1:0]   mem_waddr;
   logic [HEAD_W-1:0]   mem_wdata;
   logic [SLOT_W-1:0]   mem_raddr;
   logic [HEAD_W-1:0]   rd_data_ff;

   logic [HEAD_W-1:0]   obj_count;
   logic [HEAD_W-1:0]   head_cur;
   logic                scan_end;
   logic                head_hit;
   logic [HEAD_W-1:0]   link_next;
   logic                link_last;
   logic [HEAD_W-1:0]   link_word;
   logic                free_ok;

   // clamp object count to 1..OBJS_MAX
   always_comb begin
      if (opc_ff == '0) begin
         obj_count = HEAD_W'(1);
      end else if (opc_ff > coa_pkg::LIST_END) begin
         obj_count = coa_pkg::LIST_END;
      end else begin
         obj_count = opc_ff;
      end
   end

   assign head_cur  = chunk_head_ff[cnt_ff];
   assign scan_end  = {1'b0, cnt_ff} == active_ff;
   assign head_hit  = head_cur < coa_pkg::LIST_END;
   assign mem_raddr = {cnt_ff, head_cur[OBJ_W-1:0]};
   assign link_next = {1'b0, lnk_ff} + HEAD_W'(1);
   assign link_last = link_next == n_ff;
   assign link_word = link_last ? coa_pkg::LIST_END : link_next;
   assign free_ok   = ({1'b0, cnt_ff} < active_ff) && ({1'b0, obj_ff} < n_ff);

   assign req_if.ready  = state_ff == coa_pkg::ST_IDLE;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.slot   = rsp_slot_ff;
   assign rsp_if.status = rsp_status_ff;
   assign rsp_if.grew   = rsp_grew_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      obj_in        = obj_ff;
      lnk_in        = lnk_ff;
      n_in          = n_ff;
      active_in     = active_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      res_grew_in   = res_grew_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_load      = 1'b0;
      head_we       = 1'b0;
      head_wdata    = head_cur;
      mem_we        = 1'b0;
      mem_waddr     = {cnt_ff, lnk_ff};
      mem_wdata     = link_word;
      case (state_ff)
         coa_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               cnt_in        = '0;
               n_in          = obj_count;
               res_slot_in   = '0;
               res_status_in = coa_pkg::STAT_OK;
               res_grew_in   = 1'b0;
               case (req_if.command)
                  coa_pkg::CMD_CLEAR: begin
                     active_in = '0;
                     state_in  = coa_pkg::ST_DONE;
                  end
                  coa_pkg::CMD_ALLOC: begin
                     state_in = coa_pkg::ST_SCAN;
                  end
                  coa_pkg::CMD_FREE: begin
                     cnt_in   = req_if.free_slot[SLOT_W-1:OBJ_W];
                     obj_in   = req_if.free_slot[OBJ_W-1:0];
                     state_in = coa_pkg::ST_FREE;
                  end
                  default: begin
                     state_in = coa_pkg::ST_DONE;
                  end
               endcase
            end
         end
         coa_pkg::ST_SCAN: begin
            if (scan_end) begin
               if (active_ff < coa_pkg::ACTIVE_MAX) begin
                  lnk_in   = '0;
                  state_in = coa_pkg::ST_LINK;
               end else begin
                  res_status_in = coa_pkg::STAT_EXHAUSTED;
                  state_in      = coa_pkg::ST_DONE;
               end
            end else if (head_hit) begin
               res_slot_in = mem_raddr;
               state_in    = coa_pkg::ST_POP;
            end else begin
               cnt_in = cnt_ff + CHUNK_W'(1);
            end
         end
         coa_pkg::ST_POP: begin
            head_we    = 1'b1;
            head_wdata = rd_data_ff;
            state_in   = coa_pkg::ST_DONE;
         end
         coa_pkg::ST_LINK: begin
            mem_we = 1'b1;
            lnk_in = link_next[OBJ_W-1:0];
            if (link_last) begin
               head_we     = 1'b1;
               head_wdata  = (n_ff == HEAD_W'(1)) ? coa_pkg::LIST_END : HEAD_W'(1);
               active_in   = active_ff + ACTIVE_W'(1);
               res_slot_in = {cnt_ff, {OBJ_W{1'b0}}};
               res_grew_in = 1'b1;
               state_in    = coa_pkg::ST_DONE;
            end
         end
         coa_pkg::ST_FREE: begin
            if (free_ok) begin
               mem_we     = 1'b1;
               mem_waddr  = {cnt_ff, obj_ff};
               mem_wdata  = head_cur;
               head_we    = 1'b1;
               head_wdata = {1'b0, obj_ff};
            end else begin
               res_status_in = coa_pkg::STAT_OUTSIDE;
            end
            state_in = coa_pkg::ST_DONE;
         end
         coa_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = coa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = coa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= coa_pkg::ST_IDLE;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         opc_ff       <= coa_pkg::OPC_RESET;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            opc_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      obj_ff        <= obj_in;
      lnk_ff        <= lnk_in;
      n_ff          <= n_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      res_grew_ff   <= res_grew_in;
      if (rsp_load) begin
         rsp_slot_ff   <= res_slot_ff;
         rsp_status_ff <= res_status_ff;
         rsp_grew_ff   <= res_grew_ff;
      end
      if (head_we) begin
         chunk_head_ff[cnt_ff] <= head_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_link_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slot_link_mem[mem_raddr];
   end

   a_active_range: assert property (@(posedge clock) disable iff (reset)
      active_ff <= coa_pkg::ACTIVE_MAX)
      else $error("open chunk count beyond limit");

   a_link_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == coa_pkg::ST_LINK |-> {1'b0, lnk_ff} < n_ff)
      else $error("link fill ran past object count");

   a_grew_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_grew_ff |-> rsp_status_ff == coa_pkg::STAT_OK
                                      && rsp_slot_ff[OBJ_W-1:0] == '0)
      else $error("new chunk reported with bad status or slot");

   a_exhaust_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == coa_pkg::ST_SCAN && scan_end && active_ff != coa_pkg::ACTIVE_MAX
      |=> state_ff == coa_pkg::ST_LINK)
      else $error("empty scan with room did not open a chunk");

endmodule

`default_nettype wire

>>> sim/chunked_object_pool_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chunked object pool allocator testbench
// Runs a directed table of clear, alloc, free and unused words across object count
// settings, then random phases of mostly alloc/free traffic under sender idling,
// receiver stalls and a long receiver hold. Every result word is checked against
// the table's expected value where one is given, else an in-bench pool predictor.
// ----------------------------------------------------------------------------

module chunked_object_pool_allocator_test;

   localparam logic [coa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int NUM_PHASES      = 7;
   localparam int WORDS_PER_PHASE = 125;
   localparam int PHASE_SETTING [NUM_PHASES] = '{64, 3, 1, 127, 0, 17, 2};
   localparam int PHASE_IDLE    [NUM_PHASES] = '{0, 60, 0, 35, 0, 60, 35};
   localparam int PHASE_STALL   [NUM_PHASES] = '{0, 0, 60, 35, 0, 0, 60};

   typedef struct packed {
      logic [coa_pkg::SLOT_W-1:0]   slot;
      logic [coa_pkg::STATUS_W-1:0] status;
      logic                         grew;
   } pool_result_type;

   typedef struct packed {
      logic                         is_setting;
      logic [coa_pkg::CMD_W-1:0]    cmd;
      logic [coa_pkg::SLOT_W-1:0]   free_slot;
      logic [coa_pkg::HEAD_W-1:0]   setting;
      logic                         typed;
      pool_result_type              want;
   } plan_row_type;

   localparam plan_row_type DIRECTED_PLAN [30] = '{
      '{1'b0, coa_pkg::CMD_FREE,  9'd0,   7'd0,   1'b1, '{9'd0, coa_pkg::STAT_OUTSIDE, 1'b0}},
      '{1'b0, coa_pkg::CMD_ALLOC, 9'd0,   7'd0,   1'b1, '{9'd0, coa_pkg::STAT_OK, 1'b1}},
      '{1'b0, coa_pkg::CMD_ALLOC, 9'd0,   7'd0,   1'b0, '0},
      '{1'b0, coa_pkg::CMD_FREE,  9'd1,   7'd0,   1'b0, '0},
      '{1'b0, coa_pkg::CMD_ALLOC, 9'd0,   7'd0,   1'b0, '0},
      '{1'b0, coa_pkg::CMD_FREE,  9'd63,  7'd0,   1'b0, '0},
      '{1'b0, coa_pkg::CMD_FREE,  9'd511, 7'd0,   1'b1, '{9'd0, coa_pkg::STAT_OUTSIDE, 1'b0}},
      '{1'b0, CMD_UNUSED,         9'd511, 7'd0,   1'b1, '{9'd0, coa_pkg::STAT_OK, 1'b0}},
      '{1'b0, coa_pkg::CMD_CLEAR, 9'd0,   7'd0,   1'b1, '{9'd0, coa_pkg::STAT_OK, 1'b0}},
      '{1'b0, coa_pkg::CMD_FREE,  9'd0,   7'd0,   1'b1, '{9'd0, coa_pkg::STAT_OUTSIDE, 1'b0}},
      '{1'b1, coa_pkg::CMD_CLEAR, 9'd0,   7'd1,   1'b0, '0},
      '{1'b0, coa_pkg::CMD_ALLOC, 9'd0,   7'd0,   1'b0, '0},
      '{1'b0, coa_pkg::CMD_ALLOC, 9'd0,   7'd0,   1'b0, '0},
      '{1'b0, coa_pkg::CMD_ALLOC, 9'd0,   7'd0,   1'b0, '0},
      '{1'b0, coa_pkg::CMD_ALLOC, 9'd0,   7'd0,   1'b0, '0},
      '{1'b0, coa_pkg::CMD_ALLOC, 9'd0,   7'd0,   1'b0, '0},
      '{1'b0, coa_pkg::CMD_ALLOC, 9'd0,   7'd0,   1'b0, '0},
      '{1'b0, coa_pkg::CMD_ALLOC, 9'd0,   7'd0,   1'b0, '0},
      '{1'b0, coa_pkg::CMD_ALLOC, 9'd0,   7'd0,   1'b1, '{9'd0, coa_pkg::STAT_EXHAUSTED, 1'b0}},
      '{1'b0, coa_pkg::CMD_FREE,  9'd65,  7'd0,   1'b1, '{9'd0, coa_pkg::STAT_OUTSIDE, 1'b0}},
      '{1'b0, coa_pkg::CMD_FREE,  9'd384, 7'd0,   1'b0, '0},
      '{1'b0, coa_pkg::CMD_ALLOC, 9'd0,   7'd0,   1'b0, '0},
      '{1'b1, coa_pkg::CMD_CLEAR, 9'd0,   7'd0,   1'b0, '0},
      '{1'b0, coa_pkg::CMD_FREE,  9'd448, 7'd0,   1'b1, '{9'd0, coa_pkg::STAT_OUTSIDE, 1'b0}},
      '{1'b0, coa_pkg::CMD_FREE,  9'd320, 7'd0,   1'b0, '0},
      '{1'b1, coa_pkg::CMD_CLEAR, 9'd0,   7'd127, 1'b0, '0},
      '{1'b0, coa_pkg::CMD_FREE,  9'd127, 7'd0,   1'b0, '0},
      '{1'b0, coa_pkg::CMD_ALLOC, 9'd0,   7'd0,   1'b0, '0},
      '{1'b0, coa_pkg::CMD_CLEAR, 9'd0,   7'd0,   1'b1, '{9'd0, coa_pkg::STAT_OK, 1'b0}},
      '{1'b0, coa_pkg::CMD_ALLOC, 9'd0,   7'd0,   1'b1, '{9'd0, coa_pkg::STAT_OK, 1'b1}}
   };

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_wr_en;
   logic [coa_pkg::HEAD_W-1:0]   csr_wr_data;

   coa_req_if req_bus ();
   coa_rsp_if rsp_bus ();

   chunked_object_pool_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic [coa_pkg::HEAD_W-1:0]   object_count_reg;
   int unsigned                  open_chunks;
   logic [coa_pkg::HEAD_W-1:0]   chunk_top [coa_pkg::CHUNK_LIMIT];
   logic [coa_pkg::HEAD_W-1:0]   next_free [coa_pkg::SLOTS];

   pool_result_type              expected_results [$];
   logic [coa_pkg::SLOT_W-1:0]   live_slots [$];
   int                           mismatch_count = 0;
   int                           send_idle_pct = 0;
   int                           rsp_stall_pct = 0;
   int                           rsp_hold_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic pool_result_type next_pool_result(
         input logic [coa_pkg::CMD_W-1:0] cmd,
         input logic [coa_pkg::SLOT_W-1:0] fs);
      pool_result_type r;
      int unsigned     n, c, i, s, base, ch, obj;
      logic            found;
      r = '0;
      found = 1'b0;
      if (object_count_reg == 0) n = 1;
      else if (object_count_reg > coa_pkg::OBJS_MAX) n = coa_pkg::OBJS_MAX;
      else n = 32'(object_count_reg);
      case (cmd)
         coa_pkg::CMD_CLEAR: begin
            open_chunks = 0;
         end
         coa_pkg::CMD_ALLOC: begin
            for (c = 0; c < open_chunks; c++) begin
               if (!found && chunk_top[c] < coa_pkg::LIST_END) begin
                  s = c * coa_pkg::OBJS_MAX + chunk_top[c];
                  chunk_top[c] = next_free[s];
                  r.slot = coa_pkg::SLOT_W'(s);
                  found = 1'b1;
               end
            end
            if (!found) begin
               if (open_chunks < coa_pkg::CHUNK_LIMIT - 1) begin
                  base = open_chunks * coa_pkg::OBJS_MAX;
                  for (i = 0; i < n; i++)
                     next_free[base + i] = (i + 1 < n) ? coa_pkg::HEAD_W'(i + 1)
                                                       : coa_pkg::LIST_END;
                  chunk_top[open_chunks] = next_free[base];
                  open_chunks++;
                  r.slot = coa_pkg::SLOT_W'(base);
                  r.grew = 1'b1;
               end else begin
                  r.status = coa_pkg::STAT_EXHAUSTED;
               end
            end
         end
         coa_pkg::CMD_FREE: begin
            ch  = fs / coa_pkg::OBJS_MAX;
            obj = fs % coa_pkg::OBJS_MAX;
            if (ch < open_chunks && obj < n) begin
               next_free[ch * coa_pkg::OBJS_MAX + obj] = chunk_top[ch];
               chunk_top[ch] = coa_pkg::HEAD_W'(obj);
            end else begin
               r.status = coa_pkg::STAT_OUTSIDE;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_word(input logic [coa_pkg::CMD_W-1:0] cmd,
                            input logic [coa_pkg::SLOT_W-1:0] fs,
                            input logic typed, input pool_result_type want);
      pool_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.command   <= cmd;
      req_bus.free_slot <= fs;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = next_pool_result(cmd, fs);
      expected_results.push_back(typed ? want : predicted);
      if (cmd == coa_pkg::CMD_CLEAR)
         live_slots.delete();
      else if (cmd == coa_pkg::CMD_ALLOC && predicted.status == coa_pkg::STAT_OK)
         live_slots.push_back(predicted.slot);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_setting(input logic [coa_pkg::HEAD_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      object_count_reg = value;
   endtask

   // receiver: random stalls, plus a counted hold when requested
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      pool_result_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.slot   = rsp_bus.slot;
         got.status = rsp_bus.status;
         got.grew   = rsp_bus.grew;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t unexpected result word: slot %0d status %0d grew %0d",
                        $realtime, got.slot, got.status, got.grew);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t mismatch exp/act: slot %0d/%0d status %0d/%0d grew %0d/%0d",
                           $realtime, want.slot, got.slot, want.status, got.status,
                           want.grew, got.grew);
            end
         end
      end
   end

   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int                           p, k, r, pick;
      logic [coa_pkg::CMD_W-1:0]    cmd;
      logic [coa_pkg::SLOT_W-1:0]   fs;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.command   <= coa_pkg::CMD_CLEAR;
      req_bus.free_slot <= '0;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      object_count_reg = coa_pkg::OPC_RESET;
      open_chunks = 0;
      for (r = 0; r < coa_pkg::CHUNK_LIMIT; r++) chunk_top[r] = '0;
      for (r = 0; r < coa_pkg::SLOTS; r++) next_free[r] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < 30; r++) begin
         if (DIRECTED_PLAN[r].is_setting) begin
            wait_drained();
            write_setting(DIRECTED_PLAN[r].setting);
         end else begin
            send_word(DIRECTED_PLAN[r].cmd, DIRECTED_PLAN[r].free_slot,
                      DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].want);
         end
      end

      for (p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         write_setting(coa_pkg::HEAD_W'(PHASE_SETTING[p]));
         send_idle_pct = PHASE_IDLE[p];
         rsp_stall_pct = PHASE_STALL[p];
         // hold the receiver off while words keep coming
         if (p == 4) rsp_hold_cycles = 300;
         for (k = 0; k < WORDS_PER_PHASE; k++) begin
            if (p == 2 && k == 60) wait_drained();
            pick = $urandom_range(99);
            fs = coa_pkg::SLOT_W'($urandom_range(coa_pkg::SLOTS - 1));
            if (pick < 2) begin
               cmd = coa_pkg::CMD_CLEAR;
            end else if (pick < 5) begin
               cmd = CMD_UNUSED;
            end else if (pick < 12) begin
               cmd = coa_pkg::CMD_FREE;
            end else if (pick < 60 || live_slots.size() == 0) begin
               cmd = coa_pkg::CMD_ALLOC;
            end else begin
               cmd = coa_pkg::CMD_FREE;
               r = $urandom_range(live_slots.size() - 1);
               fs = live_slots[r];
               live_slots.delete(r);
            end
            send_word(cmd, fs, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
